// File: rtl/core/tcs_pkg.sv
// Shared types and constants for the transport candidate selector.
package tcs_pkg;

  // Capability mask bit positions
  localparam int unsigned CAP_CONTROL   = 0;
  localparam int unsigned CAP_BULK      = 1;
  localparam int unsigned CAP_SCATTER   = 2;
  localparam int unsigned CAP_ENCRYPTED = 3;
  localparam int unsigned CAP_GPU       = 4;
  localparam int unsigned CAP_REGHOST   = 5;

  // Option flag bit positions
  localparam int unsigned OPT_ENCRYPT   = 0;
  localparam int unsigned OPT_STAGING   = 1;
  localparam int unsigned OPT_PREF_ONLY = 2;

  // Memory classes
  localparam logic [1:0] MEM_HOST   = 2'd0;
  localparam logic [1:0] MEM_PINNED = 2'd1;
  localparam logic [1:0] MEM_DEVICE = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_BYTES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BULK_BYTES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTSTANDING    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GATHER_ENTRIES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_KIND    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OPTION_FLAGS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PREFERRED_ID   = 3'd6;

  // Error codes
  localparam logic [1:0] ERR_NONE           = 2'd0;
  localparam logic [1:0] ERR_NO_CANDIDATES  = 2'd1;
  localparam logic [1:0] ERR_NO_COMPATIBLE  = 2'd2;
  localparam logic [1:0] ERR_PREF_MISSING   = 2'd3;

  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned CFG_DATA_W = 32;

  typedef struct packed {
    logic        list_empty;
    logic        available;
    logic [7:0]  name_id;
    logic [5:0]  capability_mask;
    logic [31:0] max_control_bytes;
    logic [31:0] max_bulk_bytes;
    logic [15:0] max_outstanding;
    logic [15:0] max_gather_entries;
    logic [15:0] priority_req;
    logic        last_item;
  } item_t;

endpackage

// File: rtl/core/transport_candidate_selector_unit.sv
// Transport candidate selector: ranks a streamed candidate list and reports the winner.
//
//  channel   | dir | handshake                       | content
//  s_axis    | in  | s_axis_tvalid / s_axis_tready   | one candidate, tlast or tuser ends the list
//  m_axis    | out | m_axis_tvalid / m_axis_tready   | one result per list
//  cfg       | in  | cfg_valid / cfg_ready           | request register writes
//
// One candidate per cycle unless a result stalls: an input register feeds a single
// compare/rank stage that updates the kept best and, at the end of a list, loads the
// result register. A result is valid once the rank stage has taken the closing item.
// Reset (rst, synchronous) clears list state and valids, resets request registers.
// A stalled result holds a closing item in the input register, which takes no item.
module transport_candidate_selector_unit #(
  parameter int unsigned MAX_CANDIDATES = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] available, [8:1] name_id, [14:9] capability_mask, [46:15] max_control_bytes,
  // [78:47] max_bulk_bytes, [94:79] max_outstanding, [110:95] max_gather_entries,
  // [126:111] priority_req, [127] zero
  input  logic [tcs_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // [0] list_empty
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] selected_index, [8] staging_used, [10:9] error_code, [15:11] zero
  output logic [tcs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcs_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tcs_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_CANDIDATES + 1);

  // request registers
  logic [31:0] control_bytes;
  logic [31:0] bulk_bytes;
  logic [15:0] outstanding_needed;
  logic [15:0] gather_entries_needed;
  logic [1:0]  memory_kind;
  logic [2:0]  option_flags;
  logic [7:0]  preferred_id;

  // input register
  logic  in_valid;
  item_t in_item;

  // list state
  logic [POS_W-1:0] item_position;
  logic             have_winner;
  logic [7:0]       winner_index;
  logic [15:0]      winner_priority;
  logic             winner_is_preferred;
  logic [3:0]       winner_score;
  logic             winner_staging;
  logic             preferred_was_seen;

  // result register
  logic       out_valid;
  logic [7:0] out_index;
  logic       out_staging;
  logic [1:0] out_error;

  // rank stage
  logic             proc_fire;
  logic             list_end;
  logic             take;
  logic             pref;
  logic             fit;
  logic             mem_ok;
  logic             staging;
  logic             better;
  logic [3:0]       score;
  logic [5:0]       caps;
  logic [POS_W-1:0] item_position_next;
  logic             have_winner_next;
  logic [7:0]       winner_index_next;
  logic             winner_staging_next;
  logic             preferred_was_seen_next;
  logic [1:0]       error_next;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !in_valid || proc_fire;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_error, out_staging, out_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      control_bytes         <= '0;
      bulk_bytes            <= '0;
      outstanding_needed    <= 16'd1;
      gather_entries_needed <= 16'd1;
      memory_kind           <= MEM_HOST;
      option_flags          <= '0;
      preferred_id          <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CONTROL_BYTES:  control_bytes         <= cfg_data;
        REG_BULK_BYTES:     bulk_bytes            <= cfg_data;
        REG_OUTSTANDING:    outstanding_needed    <= cfg_data[15:0];
        REG_GATHER_ENTRIES: gather_entries_needed <= cfg_data[15:0];
        REG_MEMORY_KIND:    memory_kind           <= cfg_data[1:0];
        REG_OPTION_FLAGS:   option_flags          <= cfg_data[2:0];
        REG_PREFERRED_ID:   preferred_id          <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.list_empty         <= s_axis_tuser;
      in_item.available          <= s_axis_tdata[0];
      in_item.name_id            <= s_axis_tdata[8:1];
      in_item.capability_mask    <= s_axis_tdata[14:9];
      in_item.max_control_bytes  <= s_axis_tdata[46:15];
      in_item.max_bulk_bytes     <= s_axis_tdata[78:47];
      in_item.max_outstanding    <= s_axis_tdata[94:79];
      in_item.max_gather_entries <= s_axis_tdata[110:95];
      in_item.priority_req       <= s_axis_tdata[126:111];
      in_item.last_item          <= s_axis_tlast;
    end
  end

  always_comb begin
    caps     = in_item.capability_mask;
    list_end = in_item.list_empty || in_item.last_item;
    take     = !in_item.list_empty && (item_position < POS_W'(MAX_CANDIDATES));
    pref     = (preferred_id != 8'd0) && (in_item.name_id == preferred_id);
    score    = {caps[CAP_GPU], caps[CAP_REGHOST], caps[CAP_SCATTER], caps[CAP_ENCRYPTED]};

    // device memory without gpu access falls back to host staging
    staging = 1'b0;
    priority if (memory_kind == MEM_DEVICE && !caps[CAP_GPU]) begin
      mem_ok  = option_flags[OPT_STAGING] && caps[CAP_REGHOST];
      staging = 1'b1;
    end else if (memory_kind == MEM_PINNED) begin
      mem_ok = caps[CAP_REGHOST];
    end else begin
      mem_ok = 1'b1;
    end

    fit = in_item.available && (in_item.name_id != 8'd0) && caps[CAP_CONTROL]
        && !((bulk_bytes != 32'd0) && !caps[CAP_BULK])
        && !((gather_entries_needed > 16'd1) && !caps[CAP_SCATTER])
        && !(option_flags[OPT_ENCRYPT] && !caps[CAP_ENCRYPTED])
        && (control_bytes <= in_item.max_control_bytes)
        && (bulk_bytes <= in_item.max_bulk_bytes)
        && (outstanding_needed != 16'd0)
        && (outstanding_needed <= in_item.max_outstanding)
        && (gather_entries_needed != 16'd0)
        && (gather_entries_needed <= in_item.max_gather_entries)
        && mem_ok
        && !(option_flags[OPT_PREF_ONLY] && !pref);

    better = !have_winner
          || (in_item.priority_req > winner_priority)
          || ((in_item.priority_req == winner_priority)
              && ((pref && !winner_is_preferred)
                  || ((pref == winner_is_preferred) && (score > winner_score))));

    item_position_next      = take ? item_position + POS_W'(1) : item_position;
    preferred_was_seen_next = preferred_was_seen || (take && pref && in_item.available);
    have_winner_next        = have_winner || (take && fit);
    winner_index_next       = (take && fit && better) ? 8'(item_position) : winner_index;
    winner_staging_next     = (take && fit && better) ? staging : winner_staging;

    priority if (item_position_next == '0) begin
      error_next = ERR_NO_CANDIDATES;
    end else if (have_winner_next) begin
      error_next = ERR_NONE;
    end else if (option_flags[OPT_PREF_ONLY] && !preferred_was_seen_next) begin
      error_next = ERR_PREF_MISSING;
    end else begin
      error_next = ERR_NO_COMPATIBLE;
    end

    proc_fire = in_valid && (!list_end || !out_valid || m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_position       <= '0;
      have_winner         <= 1'b0;
      winner_index        <= '0;
      winner_priority     <= '0;
      winner_is_preferred <= 1'b0;
      winner_score        <= '0;
      winner_staging      <= 1'b0;
      preferred_was_seen  <= 1'b0;
    end else if (proc_fire) begin
      if (list_end) begin
        item_position       <= '0;
        have_winner         <= 1'b0;
        winner_index        <= '0;
        winner_priority     <= '0;
        winner_is_preferred <= 1'b0;
        winner_score        <= '0;
        winner_staging      <= 1'b0;
        preferred_was_seen  <= 1'b0;
      end else begin
        item_position      <= item_position_next;
        have_winner        <= have_winner_next;
        winner_index       <= winner_index_next;
        winner_staging     <= winner_staging_next;
        preferred_was_seen <= preferred_was_seen_next;
        if (take && fit && better) begin
          winner_priority     <= in_item.priority_req;
          winner_is_preferred <= pref;
          winner_score        <= score;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && list_end) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && list_end) begin
      out_index   <= have_winner_next ? winner_index_next : 8'd0;
      out_staging <= have_winner_next && winner_staging_next;
      out_error   <= error_next;
    end
  end

endmodule

// File: rtl/core/tcs_checker.sv
// Port-level checks for the transport candidate selector, bound to the top level.
module tcs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tcs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import tcs_pkg::*;

  // no result may survive a reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a failed selection reports no winner
  a_error_no_winner: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[10:9] != ERR_NONE))
      |-> (m_axis_tdata[8:0] == 9'd0))
    else $error("error result carries a winner");

  // staging only ever comes with a winner
  a_staging_needs_winner: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[10:9] == ERR_NONE))
    else $error("staging flagged without a winner");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind transport_candidate_selector_unit tcs_checker u_tcs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: verif/tb_transport_candidate_selector_unit.sv
// Self-checking testbench for transport_candidate_selector_unit.
`timescale 1ns / 100ps

import tcs_pkg::*;

typedef struct {
  logic [7:0] sel_index;
  logic       staging;
  logic [1:0] err;
} selection_t;

typedef enum {SET_LAX, SET_MAX, SET_MIN, SET_RANDOM} setting_mode_t;

class selection_scoreboard;
  int unsigned list_limit;
  int unsigned errors;
  // request registers
  logic [31:0] req_control;
  logic [31:0] req_bulk;
  logic [15:0] req_outstanding;
  logic [15:0] req_gather;
  logic [1:0]  req_memory;
  logic [2:0]  req_options;
  logic [7:0]  req_preferred;
  // running list state
  int unsigned position;
  bit          have_best;
  bit          best_preferred;
  bit          best_staging;
  bit          pref_hit;
  logic [7:0]  best_index;
  logic [15:0] best_prio;
  logic [3:0]  best_score;
  selection_t  expected[$];

  function new(int unsigned max_list);
    list_limit      = max_list;
    errors          = 0;
    req_control     = '0;
    req_bulk        = '0;
    req_outstanding = 16'd1;
    req_gather      = 16'd1;
    req_memory      = MEM_HOST;
    req_options     = '0;
    req_preferred   = '0;
    clear_list();
  endfunction

  function void clear_list();
    position       = 0;
    have_best      = 1'b0;
    best_preferred = 1'b0;
    best_staging   = 1'b0;
    pref_hit       = 1'b0;
    best_index     = '0;
    best_prio      = '0;
    best_score     = '0;
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    case (idx)
      REG_CONTROL_BYTES:  req_control     = value;
      REG_BULK_BYTES:     req_bulk        = value;
      REG_OUTSTANDING:    req_outstanding = value[15:0];
      REG_GATHER_ENTRIES: req_gather      = value[15:0];
      REG_MEMORY_KIND:    req_memory      = value[1:0];
      REG_OPTION_FLAGS:   req_options     = value[2:0];
      REG_PREFERRED_ID:   req_preferred   = value[7:0];
      default: ;
    endcase
  endfunction

  function bit fits(item_t c, output bit staging);
    logic [5:0] caps;
    caps    = c.capability_mask;
    staging = 1'b0;
    if (!c.available || c.name_id == 8'd0) return 1'b0;
    if (!caps[CAP_CONTROL]) return 1'b0;
    if (req_bulk != 0 && !caps[CAP_BULK]) return 1'b0;
    if (req_gather > 1 && !caps[CAP_SCATTER]) return 1'b0;
    if (req_options[OPT_ENCRYPT] && !caps[CAP_ENCRYPTED]) return 1'b0;
    if (req_control > c.max_control_bytes || req_bulk > c.max_bulk_bytes) return 1'b0;
    if (req_outstanding == 0 || req_outstanding > c.max_outstanding) return 1'b0;
    if (req_gather == 0 || req_gather > c.max_gather_entries) return 1'b0;
    // device memory without gpu access falls back to host staging
    if (req_memory == MEM_DEVICE && !caps[CAP_GPU]) begin
      if (!req_options[OPT_STAGING] || !caps[CAP_REGHOST]) return 1'b0;
      staging = 1'b1;
      return 1'b1;
    end
    if (req_memory == MEM_PINNED && !caps[CAP_REGHOST]) return 1'b0;
    return 1'b1;
  endfunction

  function void rank(item_t c);
    bit         pref;
    bit         staging;
    logic [3:0] score;
    pref = (req_preferred != 8'd0) && (c.name_id == req_preferred);
    if (pref && c.available) pref_hit = 1'b1;
    if (req_options[OPT_PREF_ONLY] && !pref) return;
    if (!fits(c, staging)) return;
    score = {c.capability_mask[CAP_GPU], c.capability_mask[CAP_REGHOST],
             c.capability_mask[CAP_SCATTER], c.capability_mask[CAP_ENCRYPTED]};
    if (!have_best || c.priority_req > best_prio ||
        (c.priority_req == best_prio &&
         ((pref && !best_preferred) || (pref == best_preferred && score > best_score)))) begin
      have_best      = 1'b1;
      best_index     = 8'(position);
      best_prio      = c.priority_req;
      best_preferred = pref;
      best_score     = score;
      best_staging   = staging;
    end
  endfunction

  function void note_item(item_t c);
    selection_t r;
    if (!c.list_empty && position < list_limit) begin
      rank(c);
      position++;
    end
    if (!c.list_empty && !c.last_item) return;
    if (position == 0) r.err = ERR_NO_CANDIDATES;
    else if (have_best) r.err = ERR_NONE;
    else if (req_options[OPT_PREF_ONLY] && !pref_hit) r.err = ERR_PREF_MISSING;
    else r.err = ERR_NO_COMPATIBLE;
    r.sel_index = have_best ? best_index : 8'd0;
    r.staging   = have_best && best_staging;
    expected.push_back(r);
    clear_list();
  endfunction

  function int unsigned pending();
    return expected.size();
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task check_result(logic [15:0] data);
    selection_t want;
    if (expected.size() == 0) begin
      report_mismatch("result with no list closed", 32'(data), 32'd0);
      return;
    end
    want = expected.pop_front();
    if (data[7:0] !== want.sel_index)
      report_mismatch("selected_index", 32'(data[7:0]), 32'(want.sel_index));
    if (data[8] !== want.staging)
      report_mismatch("staging_used", 32'(data[8]), 32'(want.staging));
    if (data[10:9] !== want.err)
      report_mismatch("error_code", 32'(data[10:9]), 32'(want.err));
  endtask
endclass

module tb_transport_candidate_selector_unit;
  localparam int unsigned LIST_MAX = 256;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  selection_scoreboard sb;
  int unsigned tx_gap_max;
  int unsigned rx_gap_max;
  int unsigned rx_hold;
  int unsigned items_sent;

  transport_candidate_selector_unit #(.MAX_CANDIDATES(LIST_MAX)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random back-pressure, plus one long hold on request
  initial begin
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      int unsigned g;
      if (rx_hold > 0) begin
        g       = rx_hold;
        rx_hold = 0;
      end else begin
        g = $urandom_range(0, rx_gap_max);
      end
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  function automatic logic [31:0] limit32(logic [31:0] need);
    case ($urandom_range(0, 5))
      0: return need;
      1: return (need > 32'hFFFF_FF00) ? 32'hFFFF_FFFF : need + $urandom_range(1, 255);
      2: return 32'hFFFF_FFFF;
      3: return need - 1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] limit16(logic [15:0] need);
    case ($urandom_range(0, 5))
      0: return need;
      1: return (need > 16'hFF00) ? 16'hFFFF : need + 16'($urandom_range(1, 255));
      2: return 16'hFFFF;
      3: return need - 1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic item_t plain_candidate(logic [15:0] prio, logic [5:0] caps,
                                            logic [7:0] name, logic last);
    item_t c;
    c                    = '0;
    c.available          = 1'b1;
    c.name_id            = name;
    c.capability_mask    = caps;
    c.max_control_bytes  = 32'hFFFF_FFFF;
    c.max_bulk_bytes     = 32'hFFFF_FFFF;
    c.max_outstanding    = 16'hFFFF;
    c.max_gather_entries = 16'hFFFF;
    c.priority_req       = prio;
    c.last_item          = last;
    return c;
  endfunction

  // limits are drawn around the current request so that most candidates land near the edge
  function automatic item_t random_candidate();
    item_t c;
    c.list_empty = 1'b0;
    c.last_item  = 1'b0;
    c.available  = ($urandom_range(0, 9) != 0);
    if (sb.req_preferred != 8'd0 && $urandom_range(0, 2) == 0) c.name_id = sb.req_preferred;
    else if ($urandom_range(0, 19) == 0) c.name_id = 8'd0;
    else c.name_id = 8'($urandom_range(0, 255));
    c.capability_mask = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 3) != 0) c.capability_mask[CAP_CONTROL] = 1'b1;
    c.max_control_bytes  = limit32(sb.req_control);
    c.max_bulk_bytes     = limit32(sb.req_bulk);
    c.max_outstanding    = limit16(sb.req_outstanding);
    c.max_gather_entries = limit16(sb.req_gather);
    c.priority_req = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3))
                                                 : 16'($urandom_range(0, 65535));
    return c;
  endfunction

  task automatic send_item(item_t c);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, c.priority_req, c.max_gather_entries, c.max_outstanding,
                      c.max_bulk_bytes, c.max_control_bytes, c.capability_mask,
                      c.name_id, c.available};
    s_axis_tuser  <= c.list_empty;
    s_axis_tlast  <= c.last_item;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(c);
    items_sent++;
  endtask

  // stop offering and wait for every outstanding result, plus pipeline slack
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(setting_mode_t mode);
    logic [31:0] ctl, blk;
    logic [15:0] outs, gat;
    logic [1:0]  mem;
    logic [2:0]  opt;
    logic [7:0]  pref;
    case (mode)
      SET_MAX: begin
        ctl = 32'hFFFF_FFFF; blk = 32'hFFFF_FFFF; outs = 16'hFFFF; gat = 16'hFFFF;
        mem = MEM_DEVICE; opt = 3'b111; pref = 8'hFF;
      end
      SET_MIN: begin
        ctl = '0; blk = '0; outs = '0; gat = '0; mem = MEM_HOST; opt = '0; pref = '0;
      end
      SET_LAX: begin
        ctl  = $urandom_range(0, 64);
        blk  = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom_range(1, 4096));
        outs = 16'd1;
        gat  = 16'($urandom_range(1, 2));
        mem  = 2'($urandom_range(0, 2));
        opt  = 3'($urandom_range(0, 3));
        pref = 8'($urandom_range(0, 255));
      end
      default: begin
        case ($urandom_range(0, 3))
          0: ctl = '0;
          1: ctl = $urandom_range(1, 4096);
          2: ctl = 32'hFFFF_FFFF;
          default: ctl = $urandom();
        endcase
        blk  = ($urandom_range(0, 4) < 2) ? 32'd0 : $urandom();
        case ($urandom_range(0, 7))
          0: outs = '0;
          1: outs = 16'hFFFF;
          2, 3: outs = 16'($urandom_range(0, 65535));
          default: outs = 16'd1;
        endcase
        case ($urandom_range(0, 7))
          0: gat = '0;
          1: gat = 16'hFFFF;
          2, 3: gat = 16'($urandom_range(0, 65535));
          default: gat = 16'd1;
        endcase
        mem = 2'($urandom_range(0, 3));
        opt = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
          0: pref = '0;
          1: pref = 8'hFF;
          default: pref = 8'($urandom_range(1, 255));
        endcase
      end
    endcase
    drain();
    cfg_write(REG_CONTROL_BYTES, ctl);
    cfg_write(REG_BULK_BYTES, blk);
    cfg_write(REG_OUTSTANDING, 32'(outs));
    cfg_write(REG_GATHER_ENTRIES, 32'(gat));
    cfg_write(REG_MEMORY_KIND, 32'(mem));
    cfg_write(REG_OPTION_FLAGS, 32'(opt));
    cfg_write(REG_PREFERRED_ID, 32'(pref));
  endtask

  // a list with the occasional stray tlast or empty mark mixed in
  task automatic random_list(int unsigned len);
    item_t c;
    for (int unsigned i = 0; i < len; i++) begin
      c            = random_candidate();
      c.last_item  = (i == len - 1) || ($urandom_range(0, 39) == 0);
      c.list_empty = ($urandom_range(0, 29) == 0);
      send_item(c);
    end
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned goal;
    item_t       c;
    goal = items_sent + n;
    while (items_sent < goal) begin
      if ($urandom_range(0, 19) == 0) begin
        c            = random_candidate();
        c.list_empty = 1'b1;
        c.last_item  = 1'($urandom_range(0, 1));
        send_item(c);
      end else begin
        random_list(($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6));
      end
      if ($urandom_range(0, 11) == 0) drain();
    end
  endtask

  initial begin
    item_t d;
    setting_mode_t mode;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    sb         = new(LIST_MAX);
    tx_gap_max = 3;
    rx_gap_max = 3;
    rx_hold    = 0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty mark on its own, then all-ones and all-zeros candidates
    d = plain_candidate(16'd0, 6'h01, 8'd1, 1'b0);
    d.list_empty = 1'b1;
    send_item(d);
    send_item(plain_candidate(16'hFFFF, 6'h3F, 8'hFF, 1'b1));
    d = '0;
    d.last_item = 1'b1;
    send_item(d);
    // equal priority: capability score decides, earlier position on a full tie
    send_item(plain_candidate(16'd5, 6'h01, 8'd1, 1'b0));
    send_item(plain_candidate(16'd5, 6'h21, 8'd2, 1'b0));
    send_item(plain_candidate(16'd5, 6'h11, 8'd3, 1'b0));
    send_item(plain_candidate(16'd5, 6'h11, 8'd4, 1'b0));
    send_item(plain_candidate(16'd4, 6'h3F, 8'd5, 1'b1));
    // list closed by an empty mark after candidates
    send_item(plain_candidate(16'd1, 6'h01, 8'd1, 1'b0));
    send_item(plain_candidate(16'd2, 6'h01, 8'd1, 1'b0));
    d = plain_candidate(16'd9, 6'h3F, 8'd1, 1'b0);
    d.list_empty = 1'b1;
    send_item(d);

    // preferred-only with device memory and staging allowed
    drain();
    cfg_write(REG_PREFERRED_ID, 32'd9);
    cfg_write(REG_OPTION_FLAGS, 32'b110);
    cfg_write(REG_MEMORY_KIND, 32'(MEM_DEVICE));
    send_item(plain_candidate(16'd9, 6'h3F, 8'd3, 1'b0));
    d = plain_candidate(16'd9, 6'h3F, 8'd9, 1'b1);
    d.available = 1'b0;
    send_item(d);
    send_item(plain_candidate(16'd1, 6'h20, 8'd9, 1'b1));
    send_item(plain_candidate(16'd1, 6'h21, 8'd9, 1'b0));
    send_item(plain_candidate(16'd1, 6'h31, 8'd9, 1'b1));
    send_item(plain_candidate(16'd1, 6'h21, 8'd9, 1'b1));

    // unused memory kind, zero outstanding request
    drain();
    cfg_write(REG_OPTION_FLAGS, 32'd0);
    cfg_write(REG_MEMORY_KIND, 32'd3);
    cfg_write(REG_OUTSTANDING, 32'd0);
    send_item(plain_candidate(16'd1, 6'h01, 8'd1, 1'b1));
    drain();
    cfg_write(REG_OUTSTANDING, 32'd1);
    // preferred name beats a better score at equal priority
    send_item(plain_candidate(16'd7, 6'h3F, 8'd1, 1'b0));
    send_item(plain_candidate(16'd7, 6'h01, 8'd9, 1'b0));
    send_item(plain_candidate(16'd8, 6'h01, 8'd2, 1'b1));

    for (int p = 0; p < 8; p++) begin
      if (p == 0) mode = SET_MAX;
      else if (p == 1) mode = SET_MIN;
      else if (p % 3 == 0) mode = SET_LAX;
      else mode = SET_RANDOM;
      apply_setting(mode);
      tx_gap_max = (p == 2 || p == 5) ? 0 : 9;
      rx_gap_max = (p == 3 || p == 5) ? 0 : 9;
      random_phase((mode == SET_MIN) ? 8 : 12);
    end

    // long receiver hold while the sender streams back to back
    apply_setting(SET_LAX);
    tx_gap_max = 0;
    rx_gap_max = 0;
    rx_hold    = 400;
    for (int i = 0; i < 30; i++) random_list($urandom_range(1, 3));

    // overlong list: entries past the limit carry top priority and must be ignored
    apply_setting(SET_LAX);
    tx_gap_max = 2;
    rx_gap_max = 9;
    for (int i = 0; i < 300; i++) begin
      d = random_candidate();
      if (i >= LIST_MAX) begin
        d.priority_req = 16'hFFFF;
        d.available    = 1'b1;
      end
      d.last_item = (i == 299);
      send_item(d);
    end

    apply_setting(SET_RANDOM);
    tx_gap_max = 9;
    random_phase(20);

    drain();
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
